[hdl/chte_pkg.sv]
// Shared constants and types of the chained hash table engine.
package chte_pkg;

	localparam int CAPACITY   = 1024;
	localparam int MAX_CHAINS = 256;
	localparam int KEY_BYTES  = 8;

	localparam int SLOT_W  = $clog2(CAPACITY);
	localparam int LINK_W  = SLOT_W + 1;
	localparam int CHAIN_W = $clog2(MAX_CHAINS);
	localparam int NC_W    = 9;
	localparam int KEY_W   = 64;
	localparam int OFF_W   = 32;
	localparam int HASH_W  = 32;
	localparam int STAT_W  = 2;

	localparam int DIV_BITS  = 4;
	localparam int DIV_STEPS = HASH_W / DIV_BITS;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [NC_W-1:0]   NC_RESET  = NC_W'(251);
	localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(CAPACITY);
	localparam logic [OFF_W-1:0]  NO_OFFSET = '1;

	typedef enum logic [1:0] {
		CMD_FIND   = 2'd0,
		CMD_ADD    = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		RES_HIT   = 3'd0,
		RES_ADDED = 3'd1,
		RES_MISS  = 3'd2,
		RES_FULL  = 3'd3,
		RES_CLEAR = 3'd4
	} res_kind_t;

	typedef struct packed {
		logic      load;
		logic      sweep;
		logic      div_step;
		logic      head_rd;
		logic      add_commit;
		logic      walk_init;
		logic      ent_rd;
		logic      walk_next;
		logic      rem_unlink;
		logic      rem_free;
		logic      res_load;
		res_kind_t res_kind;
		logic      out_load;
	} dp_ctrl_t;

	typedef struct packed {
		cmd_t cmd;
		logic is_full;
		logic walk_end;
		logic key_hit;
		logic sweep_last;
		logic div_last;
	} dp_stat_t;

endpackage

[hdl/chte_datapath.sv]
// Datapath of the hash table: chain memories, hash divider, walk registers and result registers.
module chte_datapath #(
	parameter int KEY_BYTES = chte_pkg::KEY_BYTES
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  chte_pkg::dp_ctrl_t          ctrl,
	output chte_pkg::dp_stat_t          stat,
	input  logic [1:0]                  in_cmd,
	input  logic [chte_pkg::KEY_W-1:0]  in_key,
	input  logic [chte_pkg::OFF_W-1:0]  in_off,
	input  logic [chte_pkg::NC_W-1:0]   num_chains,
	output logic [chte_pkg::STAT_W-1:0] out_status,
	output logic [chte_pkg::SLOT_W-1:0] out_slot,
	output logic [chte_pkg::OFF_W-1:0]  out_off,
	output logic [chte_pkg::LINK_W-1:0] out_used
);
	import chte_pkg::*;

	localparam int KW = KEY_BYTES * 8;

	cmd_t                cmd_q;
	logic [KW-1:0]       key_q;
	logic [OFF_W-1:0]    off_q;
	logic [HASH_W-1:0]   dvd_q;
	logic [CHAIN_W-1:0]  rem_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [SLOT_W-1:0]   sweep_q;
	logic [LINK_W-1:0]   free_q, used_q, cur_q, prev_q, steps_q;

	logic [LINK_W-1:0] head_mem [MAX_CHAINS];
	logic [KW-1:0]     key_mem  [CAPACITY];
	logic [OFF_W-1:0]  off_mem  [CAPACITY];
	logic [LINK_W-1:0] link_mem [CAPACITY];

	logic [LINK_W-1:0] head_rd_q, link_rd_q;
	logic [KW-1:0]     key_rd_q;
	logic [OFF_W-1:0]  off_rd_q;

	logic [STAT_W-1:0] res_status_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic [OFF_W-1:0]  res_off_q;

	logic [NC_W-1:0]    divisor;
	logic [CHAIN_W-1:0] rem_nx;
	logic [CHAIN_W:0]   trial;
	logic [HASH_W-1:0]  dvd_nx;

	logic              lk_we, of_we, hd_we;
	logic [SLOT_W-1:0] lk_wa, of_wa;
	logic [LINK_W-1:0] lk_wd, hd_wd;
	logic [OFF_W-1:0]  of_wd;
	logic [CHAIN_W-1:0] hd_wa;
	logic [SLOT_W-1:0] lk_ra;

	always_comb begin
		if (num_chains == '0) begin
			divisor = NC_W'(1);
		end else if (num_chains > NC_W'(MAX_CHAINS)) begin
			divisor = NC_W'(MAX_CHAINS);
		end else begin
			divisor = num_chains;
		end
	end

	always_comb begin
		rem_nx = rem_q;
		dvd_nx = dvd_q;
		trial  = '0;
		for (int j = 0; j < DIV_BITS; j++) begin
			trial = {rem_nx, dvd_nx[HASH_W-1]};
			if (NC_W'(trial) >= divisor) begin
				trial = (CHAIN_W+1)'(NC_W'(trial) - divisor);
			end
			rem_nx = trial[CHAIN_W-1:0];
			dvd_nx = {dvd_nx[HASH_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
			sweep_q   <= '0;
			free_q    <= '0;
			used_q    <= '0;
		end else begin
			if (ctrl.load) begin
				div_cnt_q <= '0;
			end else if (ctrl.div_step) begin
				div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
			end
			if (ctrl.sweep) begin
				sweep_q <= sweep_q + SLOT_W'(1);
				free_q  <= '0;
				used_q  <= '0;
			end else if (ctrl.add_commit) begin
				free_q <= link_rd_q;
				used_q <= used_q + LINK_W'(1);
			end else if (ctrl.rem_free) begin
				free_q <= cur_q;
				if (used_q != '0) begin
					used_q <= used_q - LINK_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cmd_q <= cmd_t'(in_cmd);
			key_q <= in_key[KEY_W-1 -: KW];
			off_q <= in_off;
			dvd_q <= in_key[KEY_W-1 -: HASH_W];
			rem_q <= '0;
		end else if (ctrl.div_step) begin
			dvd_q <= dvd_nx;
			rem_q <= rem_nx;
		end
		if (ctrl.walk_init) begin
			cur_q   <= head_rd_q;
			prev_q  <= LINK_NONE;
			steps_q <= '0;
		end else if (ctrl.walk_next) begin
			prev_q  <= cur_q;
			cur_q   <= link_rd_q;
			steps_q <= steps_q + LINK_W'(1);
		end
	end

	always_comb begin
		lk_we = 1'b0;
		lk_wa = sweep_q;
		lk_wd = LINK_W'(sweep_q) + LINK_W'(1);
		of_we = 1'b0;
		of_wa = sweep_q;
		of_wd = NO_OFFSET;
		hd_we = 1'b0;
		hd_wa = rem_q;
		hd_wd = LINK_NONE;
		if (ctrl.sweep) begin
			lk_we = 1'b1;
			of_we = 1'b1;
			hd_we = LINK_W'(sweep_q) < LINK_W'(MAX_CHAINS);
			hd_wa = sweep_q[CHAIN_W-1:0];
		end else if (ctrl.add_commit) begin
			lk_we = 1'b1;
			lk_wa = free_q[SLOT_W-1:0];
			lk_wd = head_rd_q;
			of_we = 1'b1;
			of_wa = free_q[SLOT_W-1:0];
			of_wd = off_q;
			hd_we = 1'b1;
			hd_wd = free_q;
		end else if (ctrl.rem_unlink) begin
			if (prev_q[SLOT_W]) begin
				hd_we = 1'b1;
				hd_wd = link_rd_q;
			end else begin
				lk_we = 1'b1;
				lk_wa = prev_q[SLOT_W-1:0];
				lk_wd = link_rd_q;
			end
		end else if (ctrl.rem_free) begin
			lk_we = 1'b1;
			lk_wa = cur_q[SLOT_W-1:0];
			lk_wd = free_q;
			of_we = 1'b1;
			of_wa = cur_q[SLOT_W-1:0];
		end
	end

	assign lk_ra = ctrl.ent_rd ? cur_q[SLOT_W-1:0] : free_q[SLOT_W-1:0];

	always_ff @(posedge clk) begin
		if (lk_we) begin
			link_mem[lk_wa] <= lk_wd;
		end
		if (ctrl.head_rd || ctrl.ent_rd) begin
			link_rd_q <= link_mem[lk_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (of_we) begin
			off_mem[of_wa] <= of_wd;
		end
		if (ctrl.ent_rd) begin
			off_rd_q <= off_mem[cur_q[SLOT_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.add_commit) begin
			key_mem[free_q[SLOT_W-1:0]] <= key_q;
		end
		if (ctrl.ent_rd) begin
			key_rd_q <= key_mem[cur_q[SLOT_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (hd_we) begin
			head_mem[hd_wa] <= hd_wd;
		end
		if (ctrl.head_rd) begin
			head_rd_q <= head_mem[rem_q];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.res_load) begin
			case (ctrl.res_kind)
				RES_HIT: begin
					res_status_q <= ST_OK;
					res_slot_q   <= cur_q[SLOT_W-1:0];
					res_off_q    <= off_rd_q;
				end
				RES_ADDED: begin
					res_status_q <= ST_OK;
					res_slot_q   <= free_q[SLOT_W-1:0];
					res_off_q    <= off_q;
				end
				RES_MISS: begin
					res_status_q <= ST_MISS;
					res_slot_q   <= '0;
					res_off_q    <= NO_OFFSET;
				end
				RES_FULL: begin
					res_status_q <= ST_FULL;
					res_slot_q   <= '0;
					res_off_q    <= NO_OFFSET;
				end
				default: begin
					res_status_q <= ST_OK;
					res_slot_q   <= '0;
					res_off_q    <= NO_OFFSET;
				end
			endcase
		end
		if (ctrl.out_load) begin
			out_status <= res_status_q;
			out_slot   <= res_slot_q;
			out_off    <= res_off_q;
			out_used   <= used_q;
		end
	end

	assign stat.cmd        = cmd_q;
	assign stat.is_full    = (used_q >= LINK_W'(CAPACITY)) || free_q[SLOT_W];
	assign stat.walk_end   = cur_q[SLOT_W] || steps_q[SLOT_W];
	assign stat.key_hit    = key_rd_q == key_q;
	assign stat.sweep_last = sweep_q == '1;
	assign stat.div_last   = div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1);

endmodule

[hdl/chte_controller.sv]
// Controller state machine that sequences hashing, chain walks, updates and the table sweep.
module chte_controller (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         in_cmd,
	output logic               out_valid,
	input  logic               out_ready,
	input  chte_pkg::dp_stat_t stat,
	output chte_pkg::dp_ctrl_t ctrl
);
	import chte_pkg::*;

	typedef enum logic [9:0] {
		S_SWEEP = 10'b0000000001,
		S_IDLE  = 10'b0000000010,
		S_HASH  = 10'b0000000100,
		S_HEAD  = 10'b0000001000,
		S_HEADW = 10'b0000010000,
		S_WALK  = 10'b0000100000,
		S_CMP   = 10'b0001000000,
		S_REM1  = 10'b0010000000,
		S_REM2  = 10'b0100000000,
		S_DONE  = 10'b1000000000
	} state_t;

	state_t state_q, state_nx;
	logic   clr_rsp_q, out_valid_q;

	always_comb begin
		state_nx = state_q;
		ctrl     = '0;
		ctrl.res_kind = RES_CLEAR;
		in_ready = 1'b0;
		case (state_q)
			S_SWEEP: begin
				ctrl.sweep = 1'b1;
				if (stat.sweep_last) begin
					if (clr_rsp_q) begin
						ctrl.res_load = 1'b1;
						ctrl.res_kind = RES_CLEAR;
						state_nx      = S_DONE;
					end else begin
						state_nx = S_IDLE;
					end
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctrl.load = 1'b1;
					state_nx  = (cmd_t'(in_cmd) == CMD_CLEAR) ? S_SWEEP : S_HASH;
				end
			end
			S_HASH: begin
				ctrl.div_step = 1'b1;
				if (stat.div_last) begin
					state_nx = S_HEAD;
				end
			end
			S_HEAD: begin
				if (stat.cmd == CMD_ADD && stat.is_full) begin
					ctrl.res_load = 1'b1;
					ctrl.res_kind = RES_FULL;
					state_nx      = S_DONE;
				end else begin
					ctrl.head_rd = 1'b1;
					state_nx     = S_HEADW;
				end
			end
			S_HEADW: begin
				if (stat.cmd == CMD_ADD) begin
					ctrl.add_commit = 1'b1;
					ctrl.res_load   = 1'b1;
					ctrl.res_kind   = RES_ADDED;
					state_nx        = S_DONE;
				end else begin
					ctrl.walk_init = 1'b1;
					state_nx       = S_WALK;
				end
			end
			S_WALK: begin
				if (stat.walk_end) begin
					ctrl.res_load = 1'b1;
					ctrl.res_kind = RES_MISS;
					state_nx      = S_DONE;
				end else begin
					ctrl.ent_rd = 1'b1;
					state_nx    = S_CMP;
				end
			end
			S_CMP: begin
				if (stat.key_hit) begin
					ctrl.res_load = 1'b1;
					ctrl.res_kind = RES_HIT;
					state_nx      = (stat.cmd == CMD_REMOVE) ? S_REM1 : S_DONE;
				end else begin
					ctrl.walk_next = 1'b1;
					state_nx       = S_WALK;
				end
			end
			S_REM1: begin
				ctrl.rem_unlink = 1'b1;
				state_nx        = S_REM2;
			end
			S_REM2: begin
				ctrl.rem_free = 1'b1;
				state_nx      = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					ctrl.out_load = 1'b1;
					state_nx      = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SWEEP;
			clr_rsp_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (ctrl.load) begin
				clr_rsp_q <= cmd_t'(in_cmd) == CMD_CLEAR;
			end
			if (ctrl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

[hdl/chained_hash_table_engine.sv]
// Top level of the chained hash table engine with its configuration register.
// The engine takes one command a transfer on the slave stream (find, add, remove or clear)
// and returns exactly one result transfer on the master stream for each, in order.
// The chain count register sits at APB byte address 0 and should be written only while idle.
// One command is worked on at a time; a finished result waits in an output register,
// so the next command is taken while the receiver stalls, and the engine stops only
// when a second result would have to be stored.
// The hash works through the top 32 key bits, 4 bits a cycle; its remainder picks the chain.
// An add reads the chain head and loads the result register as it links in the new entry;
// a find walks the chain, where each entry costs one registered read of the entry memories
// and one compare, and loads the result register on a hit or at the chain's end; a remove
// that hits then unlinks the entry and then frees its slot. The output register is loaded
// from the result register once any earlier result has been taken, and then a new command can be taken.
// Clear and reset both sweep the 1024 entries of the table, one entry a cycle, so no command
// is accepted until the sweep after reset ends, and a clear reaches the output register
// once its sweep is through.
// Reset also sets the chain count to 251 and drops any pending result.
module chained_hash_table_engine #(
	parameter int KEY_BYTES = chte_pkg::KEY_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,  // key [63:0], offset_in [95:64]
	input  logic [1:0]  s_tuser,  // cmd [1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // slot [9:0], offset_out [41:10], used_count [52:42], zero
	output logic [1:0]  m_tuser,  // status [1:0]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import chte_pkg::*;

	dp_ctrl_t          ctrl;
	dp_stat_t          stat;
	logic [NC_W-1:0]   nc_q;
	logic [STAT_W-1:0] out_status;
	logic [SLOT_W-1:0] out_slot;
	logic [OFF_W-1:0]  out_off;
	logic [LINK_W-1:0] out_used;

	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : 32'(nc_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nc_q <= NC_RESET;
		end else if (psel && penable && pwrite && pready && !paddr[2]) begin
			nc_q <= pwdata[NC_W-1:0];
		end
	end

	chte_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_cmd    (s_tuser),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	chte_datapath #(
		.KEY_BYTES (KEY_BYTES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.stat       (stat),
		.in_cmd     (s_tuser),
		.in_key     (s_tdata[63:0]),
		.in_off     (s_tdata[95:64]),
		.num_chains (nc_q),
		.out_status (out_status),
		.out_slot   (out_slot),
		.out_off    (out_off),
		.out_used   (out_used)
	);

	assign m_tdata = {3'b000, out_used, out_off, out_slot};
	assign m_tuser = out_status;

endmodule

[hdl/chte_checker.sv]
// Port-level checks of the chained hash table engine and their binding to the top level.
module chte_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata,
	input logic [1:0]  m_tuser
);
	import chte_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser != 2'd3)
		else $error("undefined status code");

	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[52:42] <= 11'(CAPACITY))
		else $error("used count beyond capacity");

	a_fail_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_MISS || m_tuser == ST_FULL)
		|-> m_tdata[9:0] == 10'd0 && m_tdata[41:10] == NO_OFFSET)
		else $error("failed command carries a slot or offset");

endmodule

bind chained_hash_table_engine chte_checker u_chte_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
